// ----- hdl/postfix_expression_evaluator_defines.svh -----
// ----------------------------------------------------------------------------
// Postfix evaluator assertion macros
// Concurrent assertion wrappers for the postfix evaluator, clocked on clk
// and disabled while rst_n is low. They compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define PFX_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("postfix evaluator: invariant violated");

// A condition that must hold in the cycle after a trigger.
`define PFX_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("postfix evaluator: sequence check failed");

`else

`define PFX_ASSERT_ALWAYS(lbl, cond)
`define PFX_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

// ----- hdl/pfx_pkg.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared constants, operator codes and control structs of the evaluator.
// ----------------------------------------------------------------------------
package pfx_pkg;

  // Default sizes of the operand stack and of the data path.
  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // ASCII codes that the evaluator acts on.
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Base of the decimal accumulator.
  localparam logic [3:0] DEC_BASE = 4'd10;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctrl_t;

  // Status from the arithmetic unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic divz;
  } alu_stat_t;

endpackage

// ----- hdl/pfx_stack.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator operand stack memory
// Single write port and single registered read port. Entries below the top
// of stack live here; the top itself is held in a register by the sequencer.
// ----------------------------------------------------------------------------
module pfx_stack #(
  parameter int DEPTH = pfx_pkg::STACK_DEPTH_DEF,
  parameter int W     = pfx_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  // Storage is undefined until written, so it carries no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/pfx_alu.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator shared arithmetic unit
// One adder serves add, subtract, shift-add multiply and restoring divide.
// Add and subtract take one step, multiply and divide take W steps.
// ----------------------------------------------------------------------------
module pfx_alu #(
  parameter int W = pfx_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pfx_pkg::alu_ctrl_t  ctrl,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output logic [W-1:0]        result,
  output pfx_pkg::alu_stat_t  stat
);

  import pfx_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          divz_r, divz_nxt;
  logic          neg_r, neg_nxt;
  alu_op_t       op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  y_r, y_nxt;
  logic [W-1:0]  z_r, z_nxt;

  logic [W-1:0]  mag_a, mag_b;
  logic [W-1:0]  rem_sh;
  logic [W:0]    ax, ay, sum;
  logic          sub;

  // Operand magnitudes for the signed divide.
  assign mag_a = a[W-1] ? (~a + W'(1)) : a;
  assign mag_b = b[W-1] ? (~b + W'(1)) : b;

  // The remainder stays below the divisor magnitude, so the top bit is free.
  assign rem_sh = {x_r[W-2:0], z_r[W-1]};

  // The one shared adder.
  always_comb begin
    ax  = {1'b0, x_r};
    ay  = {1'b0, y_r};
    sub = 1'b0;
    unique case (op_r)
      ALU_ADD: sub = 1'b0;
      ALU_SUB: sub = 1'b1;
      ALU_MUL: sub = 1'b0;
      ALU_DIV: begin
        ax  = {1'b0, rem_sh};
        sub = 1'b1;
      end
    endcase
  end

  assign sum = ax + (sub ? ~ay : ay) + (W+1)'(sub);

  // Load on start, then one step per cycle until the count runs out.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    divz_nxt = divz_r;
    neg_nxt  = neg_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (busy_r) begin
      unique case (op_r)
        ALU_ADD, ALU_SUB: x_nxt = sum[W-1:0];
        ALU_MUL: begin
          if (z_r[0]) begin
            x_nxt = sum[W-1:0];
          end
          y_nxt = {y_r[W-2:0], 1'b0};
          z_nxt = {1'b0, z_r[W-1:1]};
        end
        ALU_DIV: begin
          if (!sum[W]) begin
            x_nxt = sum[W-1:0];
            z_nxt = {z_r[W-2:0], 1'b1};
          end else begin
            x_nxt = rem_sh;
            z_nxt = {z_r[W-2:0], 1'b0};
          end
        end
      endcase
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (ctrl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctrl.op;
      divz_nxt = 1'b0;
      neg_nxt  = 1'b0;
      unique case (ctrl.op)
        ALU_ADD, ALU_SUB: begin
          x_nxt   = a;
          y_nxt   = b;
          cnt_nxt = CW'(1);
        end
        ALU_MUL: begin
          x_nxt   = '0;
          y_nxt   = a;
          z_nxt   = b;
          cnt_nxt = CW'(W);
        end
        ALU_DIV: begin
          x_nxt    = '0;
          y_nxt    = mag_b;
          z_nxt    = mag_a;
          neg_nxt  = a[W-1] ^ b[W-1];
          divz_nxt = (b == '0);
          cnt_nxt  = CW'(W);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      divz_r <= 1'b0;
      op_r   <= ALU_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      divz_r <= divz_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
  end

  // Final value: the quotient takes its sign here, a zero divisor gives zero.
  always_comb begin
    result = x_r;
    if (op_r == ALU_DIV) begin
      if (divz_r) begin
        result = '0;
      end else begin
        result = neg_r ? (~z_r + W'(1)) : z_r;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.divz = divz_r;

endmodule

// ----- hdl/postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a reverse Polish expression given one ASCII character per beat.
// ----------------------------------------------------------------------------
// Input channel: in_symbol and in_last, one character per beat; in_last marks
// the final character of an expression. Digits push 0..9, + - * / pop two
// operands and push the result, other characters are skipped.
// Output channel: one beat per expression, carrying out_value (the top of
// stack, or the decimal value of all digits when no operator was seen) and
// out_status (ok, underflow, overflow, divide by zero; first error kept).
// Flow per character: each character is taken in idle and handled in
// decode; + - * / then start the shared arithmetic unit in a load state and
// wait in execute, * and / paced by that unit stepping one bit per cycle.
// The final character then loads the output register in the emit state.
// Reset clears the stack pointer, accumulator and flags; the stack memory
// needs no clearing pass. A new expression may start while a result waits
// in the output register; only the next result stalls behind a receiver
// that holds out_ready low. The stack pointer, accumulator and flags clear after each result.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_defines.svh"

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_symbol,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic [1:0]                    out_status
);

  import pfx_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_EXEC,
    S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [7:0]             sym_r, sym_nxt;
  logic                   last_r, last_nxt;
  logic [SPW-1:0]         sp_r, sp_nxt;
  logic [VALUE_WIDTH-1:0] tos_r, tos_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   op_seen_r, op_seen_nxt;
  logic [1:0]             err_r, err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;
  logic [1:0]             out_status_r, out_status_nxt;

  logic                   is_digit, is_op;
  logic [7:0]             digit_full;
  logic [3:0]             digit;
  logic [SPW-1:0]         sp_m1, sp_m2;
  logic                   emit_go;
  state_t                 after_item;

  logic                   mem_wr_en, mem_rd_en;
  logic [VALUE_WIDTH-1:0] mem_rd_data;
  alu_ctrl_t              alu_ctrl;
  alu_stat_t              alu_stat;
  logic [VALUE_WIDTH-1:0] alu_result;

  // Only the first error of an expression is kept.
  function automatic logic [1:0] keep_first(input logic [1:0] cur, input logic [1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  // Character decode.
  assign is_digit   = (sym_r >= CHAR_ZERO) && (sym_r <= CHAR_NINE);
  assign is_op      = (sym_r == CHAR_PLUS) || (sym_r == CHAR_MINUS) ||
                      (sym_r == CHAR_STAR) || (sym_r == CHAR_SLASH);
  assign digit_full = sym_r - CHAR_ZERO;
  assign digit      = digit_full[3:0];

  assign sp_m1      = sp_r - SPW'(1);
  assign sp_m2      = sp_r - SPW'(2);
  assign emit_go    = !out_valid_r || out_ready;
  assign after_item = last_r ? S_EMIT : S_IDLE;

  // A push spills the old top into memory; an operator reads the entry below.
  assign mem_wr_en = (state_r == S_DECODE) && is_digit && (sp_r != '0) &&
                     (sp_r < SPW'(STACK_DEPTH));
  assign mem_rd_en = (state_r == S_DECODE) && is_op && (sp_r >= SPW'(2));

  // Operator code for the arithmetic unit.
  always_comb begin
    alu_ctrl.start = (state_r == S_LOAD);
    unique case (sym_r)
      CHAR_MINUS: alu_ctrl.op = ALU_SUB;
      CHAR_STAR:  alu_ctrl.op = ALU_MUL;
      CHAR_SLASH: alu_ctrl.op = ALU_DIV;
      default:    alu_ctrl.op = ALU_ADD;
    endcase
  end

  pfx_stack #(
    .DEPTH (STACK_DEPTH),
    .W     (VALUE_WIDTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (sp_m1[AW-1:0]),
    .wr_data (tos_r),
    .rd_en   (mem_rd_en),
    .rd_addr (sp_m2[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  pfx_alu #(
    .W (VALUE_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (alu_ctrl),
    .a      (mem_rd_data),
    .b      (tos_r),
    .result (alu_result),
    .stat   (alu_stat)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt      = state_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    sp_nxt         = sp_r;
    tos_nxt        = tos_r;
    acc_nxt        = acc_r;
    op_seen_nxt    = op_seen_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt   = in_symbol;
          last_nxt  = in_last;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = after_item;
        if (is_digit) begin
          acc_nxt = VALUE_WIDTH'(acc_r * VALUE_WIDTH'(DEC_BASE)) + VALUE_WIDTH'(digit);
          if (sp_r >= SPW'(STACK_DEPTH)) begin
            err_nxt = keep_first(err_r, ST_OVER);
          end else begin
            tos_nxt = VALUE_WIDTH'(digit);
            sp_nxt  = sp_r + SPW'(1);
          end
        end else if (is_op) begin
          op_seen_nxt = 1'b1;
          if (sp_r < SPW'(2)) begin
            err_nxt = keep_first(err_r, ST_UNDER);
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (alu_stat.done) begin
          tos_nxt   = alu_result;
          sp_nxt    = sp_m1;
          state_nxt = after_item;
          if (alu_stat.divz) begin
            err_nxt = keep_first(err_r, ST_DIVZ);
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          if (op_seen_r) begin
            out_value_nxt  = (sp_r != '0) ? tos_r : '0;
            out_status_nxt = err_r;
          end else begin
            out_value_nxt  = acc_r;
            out_status_nxt = ST_OK;
          end
          sp_nxt      = '0;
          acc_nxt     = '0;
          op_seen_nxt = 1'b0;
          err_nxt     = ST_OK;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      acc_r       <= '0;
      op_seen_r   <= 1'b0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      acc_r       <= acc_nxt;
      op_seen_r   <= op_seen_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    tos_r        <= tos_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = $signed(out_value_r);
  assign out_status = out_status_r;

  // The arithmetic unit only runs while the sequencer waits on it.
  `PFX_ASSERT_ALWAYS(a_alu_only_in_exec, !(alu_stat.busy || alu_stat.done) || state_r == S_EXEC)

  // The stack pointer never passes the stack depth.
  `PFX_ASSERT_ALWAYS(a_sp_in_range, sp_r <= SPW'(STACK_DEPTH))

  // Underflow and divide by zero can only come from an operator.
  `PFX_ASSERT_ALWAYS(a_err_needs_op, !(err_r == ST_UNDER || err_r == ST_DIVZ) || op_seen_r)

  // Loading a result clears the expression state.
  `PFX_ASSERT_NEXT(a_clear_after_result, state_r == S_EMIT && emit_go,
                   sp_r == '0 && acc_r == '0 && !op_seen_r && err_r == ST_OK && out_valid_r)

endmodule

// ----- verif/postfix_expression_evaluator_checker.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator result checker
// Watches both channels of the evaluator and keeps its own operand stack,
// decimal accumulator and error flag. Every digit or operator beat updates that state;
// a beat marked last queues the expected result. Every output beat is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_expression_evaluator_checker #(
  parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_symbol,
  input  logic                          in_last,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [VALUE_WIDTH-1:0] out_value,
  input  logic [1:0]                    out_status,
  output int                            results_owed,
  output int                            mismatch_count
);

  import pfx_pkg::*;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [1:0]             status;
  } expr_result_t;

  // Shadow state of one expression in progress.
  logic [VALUE_WIDTH-1:0] operands [STACK_DEPTH];
  int unsigned            depth;
  logic [VALUE_WIDTH-1:0] decimal_value;
  bit                     saw_operator;
  logic [1:0]             first_error;

  // Results still owed by the evaluator, oldest first.
  expr_result_t expected_results[$];

  task automatic clear_expression();
    depth         = 0;
    decimal_value = '0;
    saw_operator  = 1'b0;
    first_error   = ST_OK;
  endtask

  // Only the first error of an expression is kept.
  task automatic note_error(input logic [1:0] code);
    if (first_error == ST_OK) begin
      first_error = code;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("tb: mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : predict_and_check
    logic [VALUE_WIDTH-1:0] lhs, rhs, res, mag_l, mag_r;
    logic [3:0]             digit;
    expr_result_t           want;

    if (!rst_n) begin
      clear_expression();
      expected_results.delete();
    end else begin
      // Output beat: compare with the oldest expected result.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, value %0d status %0d",
                                    out_value, out_status));
        end else begin
          want = expected_results.pop_front();
          if (out_value !== want.value) begin
            report_mismatch($sformatf("value got %0d expected %0d",
                                      out_value, $signed(want.value)));
          end
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_status, want.status));
          end
        end
      end

      // Input beat: digits push, operators pop two and push one.
      if (in_valid && in_ready) begin
        if (in_symbol >= CHAR_ZERO && in_symbol <= CHAR_NINE) begin
          digit = 4'(in_symbol - CHAR_ZERO);
          decimal_value = decimal_value * DEC_BASE + digit;
          if (depth >= STACK_DEPTH) begin
            note_error(ST_OVER);
          end else begin
            operands[depth] = digit;
            depth++;
          end
        end else if (in_symbol == CHAR_PLUS || in_symbol == CHAR_MINUS ||
                     in_symbol == CHAR_STAR || in_symbol == CHAR_SLASH) begin
          saw_operator = 1'b1;
          if (depth < 2) begin
            note_error(ST_UNDER);
          end else begin
            rhs = operands[depth-1];
            lhs = operands[depth-2];
            depth -= 2;
            case (in_symbol)
              CHAR_PLUS:  res = lhs + rhs;
              CHAR_MINUS: res = lhs - rhs;
              CHAR_STAR:  res = lhs * rhs;
              default: begin
                if (rhs == '0) begin
                  note_error(ST_DIVZ);
                  res = '0;
                end else begin
                  // Divide magnitudes, then restore the sign: truncates toward zero.
                  mag_l = lhs[VALUE_WIDTH-1] ? -lhs : lhs;
                  mag_r = rhs[VALUE_WIDTH-1] ? -rhs : rhs;
                  res = mag_l / mag_r;
                  if (lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1]) begin
                    res = -res;
                  end
                end
              end
            endcase
            operands[depth] = res;
            depth++;
          end
        end

        // The last beat closes the expression and queues its result.
        if (in_last) begin
          if (saw_operator) begin
            want.value  = (depth > 0) ? operands[depth-1] : '0;
            want.status = first_error;
          end else begin
            want.value  = decimal_value;
            want.status = ST_OK;
          end
          expected_results.push_back(want);
          clear_expression();
        end
      end
    end
    results_owed <= expected_results.size();
  end

endmodule

// ----- verif/postfix_expression_evaluator_test.sv -----
// ----------------------------------------------------------------------------
// Postfix evaluator testbench
// Feeds the evaluator directed expressions and then random ones: mostly
// well-formed postfix with random digits and operators, plus broken
// sequences, stack overflows, long multiply chains and raw byte noise.
// Sender gaps and receiver stalls change from phase to phase; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_expression_evaluator_test;
  import pfx_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 4 * VALUE_WIDTH_DEF;
  localparam int PHASE_ITEMS  = 230;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic [7:0]                        in_symbol = 8'h00;
  logic                              in_last   = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [VALUE_WIDTH_DEF-1:0] out_value;
  logic [1:0]                        out_status;

  int          results_owed;
  int          mismatch_count;
  int          cycle_count = 0;
  int          items_sent  = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;

  // Characters of the expression about to be sent.
  logic [7:0] expr_chars[$];

  always #5 clk = ~clk;

  postfix_expression_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_symbol  (in_symbol),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

  postfix_expression_evaluator_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_status     (out_status),
    .results_owed   (results_owed),
    .mismatch_count (mismatch_count)
  );

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit is_active(input logic [7:0] c);
    return (c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_PLUS || c == CHAR_MINUS ||
           c == CHAR_STAR || c == CHAR_SLASH;
  endfunction

  task automatic add_digit();
    expr_chars.push_back(CHAR_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic add_operator();
    case ($urandom_range(3))
      0:       expr_chars.push_back(CHAR_PLUS);
      1:       expr_chars.push_back(CHAR_MINUS);
      2:       expr_chars.push_back(CHAR_STAR);
      default: expr_chars.push_back(CHAR_SLASH);
    endcase
  endtask

  // A character that the block skips.
  task automatic add_filler();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (is_active(c));
    expr_chars.push_back(c);
  endtask

  // Valid postfix with n_ops operators; the stack never runs short.
  task automatic build_wellformed(input int n_ops);
    int digits_left;
    int ops_left;
    int level;
    bit can_op;
    bit can_digit;
    digits_left = n_ops + 1;
    ops_left    = n_ops;
    level       = 0;
    while (digits_left + ops_left > 0) begin
      if ($urandom_range(9) == 0) begin
        add_filler();
      end
      can_op    = (level >= 2) && (ops_left > 0);
      can_digit = (digits_left > 0) && (level < STACK_DEPTH_DEF);
      if (can_op && (!can_digit || $urandom_range(1) == 1)) begin
        add_operator();
        ops_left--;
        level--;
      end else begin
        add_digit();
        digits_left--;
        level++;
      end
    end
  endtask

  task automatic send_beat(input logic [7:0] sym, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_last   <= lst;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_chars.size(); i++) begin
      send_beat(expr_chars[i], i == expr_chars.size() - 1);
      items_sent++;
    end
  endtask

  task automatic send_text(input string s);
    expr_chars.delete();
    for (int i = 0; i < s.len(); i++) begin
      expr_chars.push_back(s[i]);
    end
    send_expr();
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int phase_start;
    int n;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty expression, symbol extremes, every operator,
    // negative division, underflow on an empty stack, divide by zero,
    // first error kept, and a skipped character among digits.
    expr_chars = {8'h00};
    send_expr();
    expr_chars = {8'hFF, CHAR_NINE};
    send_expr();
    send_text("83-2*9/7+");
    send_text("38-2/");
    send_text("+");
    send_text("40/");
    send_text("1+0/");
    send_text("5 6");

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        expr_chars.delete();
        n = $urandom_range(99);
        if (n < 60) begin
          // Well-formed, usually short, now and then deep.
          build_wellformed(($urandom_range(7) == 0) ? $urandom_range(14, 8)
                                                    : $urandom_range(7, 1));
        end else if (n < 72) begin
          // Broken: stray leading or trailing operator, or a dropped tail.
          build_wellformed($urandom_range(5, 1));
          case ($urandom_range(2))
            0: begin
              add_operator();
              expr_chars.push_front(expr_chars.pop_back());
            end
            1: add_operator();
            default: void'(expr_chars.pop_back());
          endcase
        end else if (n < 84) begin
          // Raw byte noise of any value.
          repeat ($urandom_range(6, 1)) expr_chars.push_back(8'($urandom_range(255)));
        end else if (n < 92) begin
          // Push past a full stack, then fold part of it.
          repeat ($urandom_range(20, 17)) add_digit();
          repeat ($urandom_range(4)) add_operator();
        end else if (n < 94) begin
          // Build the most negative value by doubling, then apply it to minus one.
          expr_chars.push_back(CHAR_ZERO + 8'd2);
          repeat (30) begin
            expr_chars.push_back(CHAR_ZERO + 8'd2);
            expr_chars.push_back(CHAR_STAR);
          end
          expr_chars.push_back(CHAR_ZERO);
          expr_chars.push_back(CHAR_ZERO + 8'd1);
          expr_chars.push_back(CHAR_MINUS);
          if ($urandom_range(1) == 1) begin
            expr_chars.push_back(CHAR_SLASH);
          end else begin
            add_operator();
          end
        end else begin
          // Digits only: the decimal value wraps when long enough.
          repeat ($urandom_range(20, 1)) begin
            if ($urandom_range(7) == 0) begin
              add_filler();
            end
            add_digit();
          end
        end
        send_expr();
      end
      // Hold the sender until every result of this phase is in.
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
